/* hw/rtl/s2e_pkg.sv */
// ============================================================================
// s2e_pkg: shared types and constants of the SE(2) exponential map unit
// Fixed-point constants, CORDIC arctangent table and the cell data records.
// ============================================================================
`default_nettype none

package s2e_pkg;

  // Pipeline depths
  localparam int CORDIC_N = 30;
  localparam int DIV_N    = 48;

  // Datapath widths
  localparam int XW = 34;   // CORDIC x/y
  localparam int ZW = 34;   // CORDIC residual angle
  localparam int NW = 48;   // divider numerator / quotient
  localparam int DW = 20;   // divider divisor / remainder
  localparam int IW = 5;    // CORDIC stage index

  // Q.30 constants and the integer Taylor divisor
  localparam logic signed [35:0] Q30_ONE  = 36'sd1073741824;
  localparam logic signed [35:0] PI_Q30   = 36'sd3373259426;
  localparam logic signed [35:0] HALF_PI  = 36'sd1686629713;
  localparam logic signed [35:0] TWO_PI   = 36'sd6746518852;
  localparam logic signed [XW-1:0] CORDIC_K = 34'sd652032874;
  localparam logic [DW-1:0] TAYLOR_DIV = 20'd24;

  // Data carried alongside the angle path
  typedef struct packed {
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [19:0] a;
    logic               taylor;
  } side_t;

  // One CORDIC cell's state
  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 neg;
    side_t                side;
  } cor_t;

  // One divider cell's state (two quotients share one divisor)
  typedef struct packed {
    logic [DW-1:0]      rem_s;
    logic [DW-1:0]      rem_c;
    logic [NW-1:0]      num_s;
    logic [NW-1:0]      num_c;
    logic [NW-1:0]      q_s;
    logic [NW-1:0]      q_c;
    logic [DW-1:0]      d;
    logic               sgn_s;
    logic               sgn_c;
    logic signed [31:0] cs;
    logic signed [31:0] sn;
    side_t              side;
  } div_t;

  // Arctangent of 2^-i in Q.30
  function automatic logic signed [ZW-1:0] atan_q30(input logic [IW-1:0] i);
    logic signed [ZW-1:0] r;
    unique case (i)
      5'd0:  r = 34'sd843314857;
      5'd1:  r = 34'sd497837829;
      5'd2:  r = 34'sd263043837;
      5'd3:  r = 34'sd133525159;
      5'd4:  r = 34'sd67021687;
      5'd5:  r = 34'sd33543516;
      5'd6:  r = 34'sd16775851;
      5'd7:  r = 34'sd8388437;
      5'd8:  r = 34'sd4194283;
      5'd9:  r = 34'sd2097149;
      5'd10: r = 34'sd1048576;
      5'd11: r = 34'sd524288;
      5'd12: r = 34'sd262144;
      5'd13: r = 34'sd131072;
      5'd14: r = 34'sd65536;
      5'd15: r = 34'sd32768;
      5'd16: r = 34'sd16384;
      5'd17: r = 34'sd8192;
      5'd18: r = 34'sd4096;
      5'd19: r = 34'sd2048;
      5'd20: r = 34'sd1024;
      5'd21: r = 34'sd512;
      5'd22: r = 34'sd256;
      5'd23: r = 34'sd128;
      5'd24: r = 34'sd64;
      5'd25: r = 34'sd32;
      5'd26: r = 34'sd16;
      5'd27: r = 34'sd8;
      5'd28: r = 34'sd4;
      5'd29: r = 34'sd2;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/s2e_cordic_cell.sv */
// ============================================================================
// s2e_cordic_cell: one rotation-mode CORDIC iteration
// Rotates (x, y) by +/- atan(2^-i) toward zero residual angle and registers.
// ============================================================================
`default_nettype none

module s2e_cordic_cell (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   en,
  input  wire logic [s2e_pkg::IW-1:0] stage_idx,
  input  wire logic                   in_vld,
  input  wire s2e_pkg::cor_t          in_dat,
  output      logic                   out_vld,
  output      s2e_pkg::cor_t          out_dat
);

  logic          vld_r;
  s2e_pkg::cor_t dat_r, dat_nxt;
  logic signed [s2e_pkg::XW-1:0] sx, sy;
  logic signed [s2e_pkg::ZW-1:0] at;

  // Rotate one micro-step
  always_comb begin
    sx = in_dat.x >>> stage_idx;
    sy = in_dat.y >>> stage_idx;
    at = s2e_pkg::atan_q30(stage_idx);
    dat_nxt = in_dat;
    if (!in_dat.z[s2e_pkg::ZW-1]) begin
      dat_nxt.x = in_dat.x - sy;
      dat_nxt.y = in_dat.y + sx;
      dat_nxt.z = in_dat.z - at;
    end else begin
      dat_nxt.x = in_dat.x + sy;
      dat_nxt.y = in_dat.y - sx;
      dat_nxt.z = in_dat.z + at;
    end
  end

  // Advance valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (en) begin
      dat_r <= dat_nxt;
    end
  end

  assign out_vld = vld_r;
  assign out_dat = dat_r;

endmodule

`default_nettype wire

/* hw/rtl/s2e_div_cell.sv */
// ============================================================================
// s2e_div_cell: one restoring-division step for two quotients
// Shifts in one numerator bit per quotient and subtracts the shared divisor.
// ============================================================================
`default_nettype none

module s2e_div_cell (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          in_vld,
  input  wire s2e_pkg::div_t in_dat,
  output      logic          out_vld,
  output      s2e_pkg::div_t out_dat
);

  logic          vld_r;
  s2e_pkg::div_t dat_r, dat_nxt;
  logic [s2e_pkg::DW:0] ts, tc, dd;

  // Compare and subtract one bit of each quotient
  always_comb begin
    dat_nxt = in_dat;
    dd = {1'b0, in_dat.d};
    ts = {in_dat.rem_s, in_dat.num_s[s2e_pkg::NW-1]};
    tc = {in_dat.rem_c, in_dat.num_c[s2e_pkg::NW-1]};
    dat_nxt.num_s = {in_dat.num_s[s2e_pkg::NW-2:0], 1'b0};
    dat_nxt.num_c = {in_dat.num_c[s2e_pkg::NW-2:0], 1'b0};
    if (ts >= dd) begin
      dat_nxt.rem_s = s2e_pkg::DW'(ts - dd);
      dat_nxt.q_s   = {in_dat.q_s[s2e_pkg::NW-2:0], 1'b1};
    end else begin
      dat_nxt.rem_s = ts[s2e_pkg::DW-1:0];
      dat_nxt.q_s   = {in_dat.q_s[s2e_pkg::NW-2:0], 1'b0};
    end
    if (tc >= dd) begin
      dat_nxt.rem_c = s2e_pkg::DW'(tc - dd);
      dat_nxt.q_c   = {in_dat.q_c[s2e_pkg::NW-2:0], 1'b1};
    end else begin
      dat_nxt.rem_c = tc[s2e_pkg::DW-1:0];
      dat_nxt.q_c   = {in_dat.q_c[s2e_pkg::NW-2:0], 1'b0};
    end
  end

  // Advance valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (en) begin
      dat_r <= dat_nxt;
    end
  end

  assign out_vld = vld_r;
  assign out_dat = dat_r;

endmodule

`default_nettype wire

/* hw/rtl/se2_pose_exponential_unit.sv */
// ============================================================================
// se2_pose_exponential_unit: SE(2) exponential map of a motion increment
// Range reduction, a 30-cell CORDIC chain, a 48-cell divider chain, then
// clamp, multiply, round and saturate into the pose and heading outputs.
// ============================================================================
// Throughput: one item per cycle; the whole pipeline advances together and
//   holds while a finished result waits on out_ready.
// Reset: synchronous, active low; clears all valid bits and sets the
//   small-angle threshold to 1. No clearing pass.
`default_nettype none

module se2_pose_exponential_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [15:0]        cfg_wdata,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire logic signed [31:0] in_delta_x,
  input  wire logic signed [31:0] in_delta_y,
  input  wire logic signed [19:0] in_delta_angle,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      logic signed [31:0] out_pose_x,
  output      logic signed [31:0] out_pose_y,
  output      logic signed [17:0] out_heading_cos,
  output      logic signed [17:0] out_heading_sin
);

  localparam int CN = s2e_pkg::CORDIC_N;
  localparam int DN = s2e_pkg::DIV_N;

  logic en;
  logic [15:0] thr_r;

  // Hold the whole pipeline while the output stalls
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= 16'd1;
    end else if (cfg_we) begin
      thr_r <= cfg_wdata;
    end
  end

  // --------------------------------------------------------------------------
  // Input stage: fold the angle into [-pi/2, pi/2]
  // --------------------------------------------------------------------------
  logic signed [35:0] z0, z1, z2, z3;
  logic               neg0;
  logic [19:0]        mag0;
  s2e_pkg::cor_t      s0_nxt, s0_r;
  logic               s0_vld_r;

  always_comb begin
    z0 = $signed({{2{in_delta_angle[19]}}, in_delta_angle, 14'b0});
    z1 = (z0 > s2e_pkg::PI_Q30) ? z0 - s2e_pkg::TWO_PI : z0;
    z2 = (z1 < -s2e_pkg::PI_Q30) ? z1 + s2e_pkg::TWO_PI : z1;
    neg0 = 1'b0;
    z3 = z2;
    if (z2 > s2e_pkg::HALF_PI) begin
      z3 = z2 - s2e_pkg::PI_Q30;
      neg0 = 1'b1;
    end else if (z2 < -s2e_pkg::HALF_PI) begin
      z3 = z2 + s2e_pkg::PI_Q30;
      neg0 = 1'b1;
    end
    mag0 = in_delta_angle[19] ? 20'(-in_delta_angle) : 20'(in_delta_angle);
    s0_nxt.x = s2e_pkg::CORDIC_K;
    s0_nxt.y = '0;
    s0_nxt.z = z3[s2e_pkg::ZW-1:0];
    s0_nxt.neg = neg0;
    s0_nxt.side.dx = in_delta_x;
    s0_nxt.side.dy = in_delta_y;
    s0_nxt.side.a  = in_delta_angle;
    s0_nxt.side.taylor = (in_delta_angle == 20'sd0) || (mag0 < {4'b0, thr_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (en) begin
      s0_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_r <= s0_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // CORDIC chain
  // --------------------------------------------------------------------------
  s2e_pkg::cor_t cor_d [CN+1];
  logic [CN:0]   cor_v;

  assign cor_d[0] = s0_r;
  assign cor_v[0] = s0_vld_r;

  for (genvar i = 0; i < CN; i++) begin : g_cor
    s2e_cordic_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .stage_idx (s2e_pkg::IW'(i)),
      .in_vld    (cor_v[i]),
      .in_dat    (cor_d[i]),
      .out_vld   (cor_v[i+1]),
      .out_dat   (cor_d[i+1])
    );
  end

  // --------------------------------------------------------------------------
  // Post-CORDIC stage: sign fix, clamp, angle square
  // --------------------------------------------------------------------------
  logic signed [s2e_pkg::XW-1:0] xf, yf;
  logic signed [31:0]  cs_nxt, sn_nxt, p0_cs_r, p0_sn_r;
  logic signed [39:0]  aa_nxt;
  logic [38:0]         p0_aa_r;
  logic [19:0]         p0_mag_r;
  s2e_pkg::side_t      p0_side_r;
  logic                p0_vld_r;

  function automatic logic signed [31:0] clamp34(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sd1073741824) begin
      r = 32'sd1073741824;
    end else if (v < -34'sd1073741824) begin
      r = -32'sd1073741824;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  always_comb begin
    xf = cor_d[CN].neg ? -cor_d[CN].x : cor_d[CN].x;
    yf = cor_d[CN].neg ? -cor_d[CN].y : cor_d[CN].y;
    cs_nxt = clamp34(xf);
    sn_nxt = clamp34(yf);
    aa_nxt = cor_d[CN].side.a * cor_d[CN].side.a;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_vld_r <= 1'b0;
    end else if (en) begin
      p0_vld_r <= cor_v[CN];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0_cs_r   <= cs_nxt;
      p0_sn_r   <= sn_nxt;
      p0_aa_r   <= aa_nxt[38:0];
      p0_mag_r  <= cor_d[CN].side.a[19] ? 20'(-cor_d[CN].side.a)
                                         : 20'(cor_d[CN].side.a);
      p0_side_r <= cor_d[CN].side;
    end
  end

  // --------------------------------------------------------------------------
  // Divider chain: sin/t and (1-cos)/t, or the Taylor square over 24
  // --------------------------------------------------------------------------
  s2e_pkg::div_t div_d [DN+1];
  s2e_pkg::div_t div0_nxt;
  logic [DN:0]   div_v;
  logic [30:0]   sn_abs;
  logic [31:0]   one_m_cs;

  always_comb begin
    sn_abs   = p0_sn_r[31] ? 31'(-p0_sn_r) : 31'(p0_sn_r);
    one_m_cs = 32'(s2e_pkg::Q30_ONE[31:0] - p0_cs_r);
    div0_nxt.rem_s = '0;
    div0_nxt.rem_c = '0;
    div0_nxt.q_s   = '0;
    div0_nxt.q_c   = '0;
    div0_nxt.cs    = p0_cs_r;
    div0_nxt.sn    = p0_sn_r;
    div0_nxt.side  = p0_side_r;
    if (p0_side_r.taylor) begin
      div0_nxt.num_s = {9'b0, p0_aa_r};
      div0_nxt.num_c = '0;
      div0_nxt.d     = s2e_pkg::TAYLOR_DIV;
      div0_nxt.sgn_s = 1'b0;
      div0_nxt.sgn_c = 1'b0;
    end else begin
      div0_nxt.num_s = {1'b0, sn_abs, 16'b0};
      div0_nxt.num_c = {one_m_cs, 16'b0};
      div0_nxt.d     = p0_mag_r;
      div0_nxt.sgn_s = p0_sn_r[31] ^ p0_side_r.a[19];
      div0_nxt.sgn_c = p0_side_r.a[19];
    end
  end

  assign div_d[0] = div0_nxt;
  assign div_v[0] = p0_vld_r;

  for (genvar j = 0; j < DN; j++) begin : g_div
    s2e_div_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .in_vld  (div_v[j]),
      .in_dat  (div_d[j]),
      .out_vld (div_v[j+1]),
      .out_dat (div_d[j+1])
    );
  end

  // --------------------------------------------------------------------------
  // Form s and c, clamp; round heading to Q1.16
  // --------------------------------------------------------------------------
  logic signed [49:0] s_w, c_w;
  logic signed [31:0] s_nxt, c_nxt, p2_s_r, p2_c_r, p2_dx_r, p2_dy_r;
  logic signed [32:0] hc_w, hs_w;
  logic signed [17:0] p2_hc_r, p2_hs_r;
  logic               p2_vld_r;

  function automatic logic signed [31:0] clamp50(input logic signed [49:0] v);
    logic signed [31:0] r;
    if (v > 50'sd1073741824) begin
      r = 32'sd1073741824;
    end else if (v < -50'sd1073741824) begin
      r = -32'sd1073741824;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  always_comb begin
    if (div_d[DN].side.taylor) begin
      s_w = 50'sd1073741824 - $signed({2'b0, div_d[DN].q_s});
      c_w = $signed({{17{div_d[DN].side.a[19]}}, div_d[DN].side.a, 13'b0});
    end else begin
      s_w = div_d[DN].sgn_s ? -$signed({2'b0, div_d[DN].q_s})
                            : $signed({2'b0, div_d[DN].q_s});
      c_w = div_d[DN].sgn_c ? -$signed({2'b0, div_d[DN].q_c})
                            : $signed({2'b0, div_d[DN].q_c});
    end
    s_nxt = clamp50(s_w);
    c_nxt = clamp50(c_w);
    hc_w  = 33'(div_d[DN].cs) + 33'sd8192;
    hs_w  = 33'(div_d[DN].sn) + 33'sd8192;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_vld_r <= 1'b0;
    end else if (en) begin
      p2_vld_r <= div_v[DN];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_s_r  <= s_nxt;
      p2_c_r  <= c_nxt;
      p2_dx_r <= div_d[DN].side.dx;
      p2_dy_r <= div_d[DN].side.dy;
      p2_hc_r <= hc_w[31:14];
      p2_hs_r <= hs_w[31:14];
    end
  end

  // --------------------------------------------------------------------------
  // Products
  // --------------------------------------------------------------------------
  logic signed [63:0] p3_xs_r, p3_yc_r, p3_xc_r, p3_ys_r;
  logic signed [17:0] p3_hc_r, p3_hs_r;
  logic               p3_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_vld_r <= 1'b0;
    end else if (en) begin
      p3_vld_r <= p2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p3_xs_r <= p2_dx_r * p2_s_r;
      p3_yc_r <= p2_dy_r * p2_c_r;
      p3_xc_r <= p2_dx_r * p2_c_r;
      p3_ys_r <= p2_dy_r * p2_s_r;
      p3_hc_r <= p2_hc_r;
      p3_hs_r <= p2_hs_r;
    end
  end

  // --------------------------------------------------------------------------
  // Sums with rounding offset
  // --------------------------------------------------------------------------
  logic signed [65:0] p4_sx_r, p4_sy_r;
  logic signed [17:0] p4_hc_r, p4_hs_r;
  logic               p4_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p4_vld_r <= 1'b0;
    end else if (en) begin
      p4_vld_r <= p3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p4_sx_r <= 66'(p3_xs_r) - 66'(p3_yc_r) + 66'sd536870912;
      p4_sy_r <= 66'(p3_xc_r) + 66'(p3_ys_r) + 66'sd536870912;
      p4_hc_r <= p3_hc_r;
      p4_hs_r <= p3_hs_r;
    end
  end

  // --------------------------------------------------------------------------
  // Scale down and saturate into the output register
  // --------------------------------------------------------------------------
  logic signed [35:0] shx, shy;
  logic signed [31:0] px_nxt, py_nxt;
  logic               out_vld_r;

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -36'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  always_comb begin
    shx = p4_sx_r[65:30];
    shy = p4_sy_r[65:30];
    px_nxt = sat32(shx);
    py_nxt = sat32(shy);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= p4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_pose_x      <= px_nxt;
      out_pose_y      <= py_nxt;
      out_heading_cos <= p4_hc_r;
      out_heading_sin <= p4_hs_r;
    end
  end

  assign out_valid = out_vld_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_cos_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_heading_cos <= 18'sd65536 && out_heading_cos >= -18'sd65536))
    else $error("heading_cos out of range");

  a_sin_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_heading_sin <= 18'sd65536 && out_heading_sin >= -18'sd65536))
    else $error("heading_sin out of range");

  a_zero_taylor: assert property (@(posedge clk) disable iff (!rst_n)
    (s0_vld_r && s0_r.side.a == 20'sd0) |-> s0_r.side.taylor)
    else $error("zero angle not routed to Taylor form");

  a_s_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    p2_vld_r |-> (p2_s_r <= 32'sd1073741824 && p2_s_r >= -32'sd1073741824))
    else $error("s escaped clamp");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(div_v[DN]) && $stable(p4_vld_r))
    else $error("pipeline moved during stall");

endmodule

`default_nettype wire
